/* hdl/fsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

  // Queue between the classifying front and the arithmetic back
  localparam int unsigned QueueDepthDef = 2;

  // Configuration port
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [1:0] RegLineThr   = 2'd0;
  localparam logic [1:0] RegTempOff   = 2'd1;
  localparam logic [1:0] RegSpeedCeil = 2'd2;

  localparam logic [8:0]         LineThrRst   = 9'd150;
  localparam logic signed [7:0]  TempOffRst   = 8'sd25;
  localparam logic [14:0]        SpeedCeilRst = 15'd18000;

  // Per-line constants
  localparam logic signed [12:0] LoadMaxLo  = 13'sd1250;
  localparam logic signed [12:0] LoadMaxHi  = 13'sd2000;
  localparam logic signed [12:0] LoadOffLo  = 13'sd34;
  localparam logic signed [12:0] LoadOffHi  = 13'sd54;
  localparam logic signed [19:0] SteepLimLo = 20'sd3750;   // 3 * load max
  localparam logic signed [19:0] SteepLimHi = 20'sd6000;
  localparam logic signed [12:0] GentleLimLo = -13'sd625;  // minus half load max
  localparam logic signed [12:0] GentleLimHi = -13'sd1000;
  localparam logic [11:0]        SteepCoefLo = 12'd2764;
  localparam logic [11:0]        SteepCoefHi = 12'd1728;
  localparam logic [11:0]        GentleCoefLo = 12'd307;
  localparam logic [11:0]        GentleCoefHi = 12'd192;
  localparam logic [8:0]         VoltNomLo  = 9'd105;
  localparam logic [8:0]         VoltNomHi  = 9'd215;
  localparam logic [8:0]         BoostFactLo = 9'd419;
  localparam logic [8:0]         BoostFactHi = 9'd262;
  localparam logic [11:0]        BoostSpanMax = 12'd3750;
  localparam logic signed [17:0] LoadFloorTerm = -18'sd1500;

  typedef struct packed {
    logic               line_hi;
    logic [14:0]        temp_term;
    logic               load_floor;
    logic [11:0]        load_coef;
    logic signed [12:0] load_arg;
    logic [11:0]        boost_span;
    logic [11:0]        watts;
    logic [8:0]         boost_fact;
  } fsc_job_t;

endpackage

`default_nettype wire

/* hdl/fsc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fsc_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] inlet_temp_c;
  logic [8:0]        input_volts;
  logic [11:0]       output_watts;

  modport source (output valid, output inlet_temp_c, output input_volts,
                  output output_watts, input ready);
  modport sink   (input valid, input inlet_temp_c, input input_volts,
                  input output_watts, output ready);
endinterface

`default_nettype wire

/* hdl/fsc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fsc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] fan_speed;
  logic        line_is_high;

  modport source (output valid, output fan_speed, output line_is_high, input ready);
  modport sink   (input valid, input fan_speed, input line_is_high, output ready);
endinterface

`default_nettype wire

/* hdl/fsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  fsc_in_if.sink                 item_i,
  input  wire logic [8:0]        line_thr_i,
  input  wire logic signed [7:0] temp_offset_i,
  output fsc_pkg::fsc_job_t      job_o,
  output logic                   job_valid_o,
  input  wire logic              job_ready_i
);
  import fsc_pkg::*;

  logic               valid_q;
  fsc_job_t           job_q, job_d;
  logic               accept;

  logic signed [9:0]  t, t28, t18, t3, t33;
  logic [14:0]        temp_term;
  logic               line_hi;
  logic signed [12:0] load_max, d;
  logic signed [19:0] d100;
  logic               steep, gentle;
  logic [8:0]         volts, vh, vl;
  logic [11:0]        y;
  logic               volts_low;

  assign item_i.ready = !valid_q || job_ready_i;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    line_hi = item_i.input_volts > line_thr_i;

    // temperature curve
    t   = {{2{item_i.inlet_temp_c[7]}}, item_i.inlet_temp_c}
        - {{2{temp_offset_i[7]}}, temp_offset_i};
    t28 = t - 10'sd28;
    t18 = t - 10'sd18;
    t3  = t - 10'sd3;
    t33 = t + 10'sd33;
    if (t >= 10'sd56) begin
      temp_term = 15'd18000;
    end else if (t >= 10'sd28) begin
      temp_term = 15'd9000 + 15'(t28[4:0]) * 15'd333;
    end else if (t >= 10'sd25) begin
      temp_term = 15'd9000;
    end else if (t >= 10'sd18) begin
      temp_term = 15'd6800 + 15'(t18[2:0]) * 15'd314;
    end else if (t >= 10'sd15) begin
      temp_term = 15'd6800;
    end else if (t >= 10'sd3) begin
      temp_term = 15'd5600 + 15'(t3[3:0]) * 15'd100;
    end else if (t >= -10'sd20) begin
      temp_term = 15'd5600;
    end else if (t >= -10'sd32) begin
      temp_term = 15'd3000 + 15'(t33[3:0]) * 15'd200;
    end else begin
      temp_term = 15'd3000;
    end

    // load band
    load_max = line_hi ? LoadMaxHi : LoadMaxLo;
    d        = $signed({1'b0, item_i.output_watts}) - load_max;
    d100     = 20'(d) * 20'sd100;
    steep    = d100 > (line_hi ? SteepLimHi : SteepLimLo);
    gentle   = d >= (line_hi ? GentleLimHi : GentleLimLo);

    // low-voltage boost span
    volts     = item_i.input_volts;
    vh        = volts - 9'd176;
    vl        = volts - 9'd90;
    volts_low = volts < (line_hi ? VoltNomHi : VoltNomLo);
    if (line_hi) begin
      if (volts < 9'd176)      y = 12'd0;
      else if (volts > 9'd205) y = BoostSpanMax;
      else                     y = 12'(vh[4:0]) * 12'd129;
    end else begin
      if (volts < 9'd90)       y = 12'd0;
      else if (volts > 9'd105) y = BoostSpanMax;
      else                     y = 12'(vl[3:0]) * 12'd250;
    end

    job_d.line_hi    = line_hi;
    job_d.temp_term  = temp_term;
    job_d.load_floor = !steep && !gentle;
    job_d.load_coef  = steep ? (line_hi ? SteepCoefHi : SteepCoefLo)
                             : (line_hi ? GentleCoefHi : GentleCoefLo);
    job_d.load_arg   = steep ? d - (line_hi ? LoadOffHi : LoadOffLo) : d;
    // a zero span drops the boost
    job_d.boost_span = volts_low ? BoostSpanMax - y : 12'd0;
    job_d.watts      = item_i.output_watts;
    job_d.boost_fact = line_hi ? BoostFactHi : BoostFactLo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (job_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_o       = job_q;
  assign job_valid_o = valid_q;

endmodule

`default_nettype wire

/* hdl/fsc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fsc_pkg::fsc_job_t  push_job_i,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  output fsc_pkg::fsc_job_t       pop_job_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i
);
  import fsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fsc_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/fsc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module fsc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fsc_pkg::fsc_job_t job_i,
  input  wire logic              job_valid_i,
  output logic                   job_ready_o,
  input  wire logic [14:0]       speed_ceil_i,
  fsc_out_if.source              result_o
);
  import fsc_pkg::*;

  typedef struct packed {
    logic               line_hi;
    logic [14:0]        temp_term;
    logic               load_floor;
    logic signed [25:0] load_prod;
    logic [23:0]        span_watts;
    logic [8:0]         boost_fact;
  } fsc_s1_t;

  typedef struct packed {
    logic               line_hi;
    logic [14:0]        temp_term;
    logic signed [17:0] load_term;
    logic [13:0]        boost;
  } fsc_s2_t;

  logic        v1_q, v2_q, vo_q;
  logic        rdy1, rdy2, rdyo;
  fsc_s1_t     s1_q, s1_d;
  fsc_s2_t     s2_q, s2_d;
  logic [32:0] boost_full;
  logic signed [19:0] sum;
  logic [14:0] speed_d, speed_q;
  logic        line_q;

  assign rdyo        = !vo_q || result_o.ready;
  assign rdy2        = !v2_q || rdyo;
  assign rdy1        = !v1_q || rdy2;
  assign job_ready_o = rdy1;

  always_comb begin
    s1_d.line_hi    = job_i.line_hi;
    s1_d.temp_term  = job_i.temp_term;
    s1_d.load_floor = job_i.load_floor;
    s1_d.load_prod  = $signed({1'b0, job_i.load_coef}) * job_i.load_arg;
    s1_d.span_watts = 24'(job_i.boost_span) * 24'(job_i.watts);
    s1_d.boost_fact = job_i.boost_fact;

    boost_full      = 33'(s1_q.span_watts) * 33'(s1_q.boost_fact);
    s2_d.line_hi    = s1_q.line_hi;
    s2_d.temp_term  = s1_q.temp_term;
    // arithmetic shift floors toward minus infinity
    s2_d.load_term  = s1_q.load_floor ? LoadFloorTerm : 18'(s1_q.load_prod >>> 7);
    s2_d.boost      = boost_full[32:19];

    sum = $signed({5'b0, s2_q.temp_term}) + 20'(s2_q.load_term)
        + $signed({6'b0, s2_q.boost});
    if (sum < 20'sd0) begin
      speed_d = 15'd0;
    end else if (sum > $signed({5'b0, speed_ceil_i})) begin
      speed_d = speed_ceil_i;
    end else begin
      speed_d = sum[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= job_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdyo) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && job_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)        s2_q <= s2_d;
    if (rdyo && v2_q) begin
      speed_q <= speed_d;
      line_q  <= s2_q.line_hi;
    end
  end

  assign result_o.valid        = vo_q;
  assign result_o.fan_speed    = speed_q;
  assign result_o.line_is_high = line_q;

endmodule

`default_nettype wire

/* hdl/fan_speed_curve_unit.sv */
// Fan speed command unit.
// Path: the front register loads at the accepting edge; the item then passes a queue
//   slot, two multiply stages and the output register when nothing stalls.
// Throughput: one item per cycle while result_o is not stalled, set by the pipelined multiply stages.
// Reset: pipeline and queue empty; registers return to 150 V, 25 C, 18000 rpm.
`timescale 1ns / 1ps
`default_nettype none

module fan_speed_curve_unit #(
  parameter int unsigned QueueDepth = fsc_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  fsc_in_if.sink                            item_i,
  fsc_out_if.source                         result_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fsc_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [fsc_pkg::ApbDataW-1:0] pwdata,
  output logic      [fsc_pkg::ApbDataW-1:0] prdata,
  output logic                              pready
);
  import fsc_pkg::*;

  logic [8:0]        line_thr_q;
  logic signed [7:0] temp_off_q;
  logic [14:0]       speed_ceil_q;
  logic              cfg_write;
  logic [1:0]        reg_idx;

  fsc_job_t front_job, back_job;
  logic     front_valid, front_ready, back_valid, back_ready;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_thr_q   <= LineThrRst;
      temp_off_q   <= TempOffRst;
      speed_ceil_q <= SpeedCeilRst;
    end else if (cfg_write) begin
      case (reg_idx)
        RegLineThr:   line_thr_q   <= pwdata[8:0];
        RegTempOff:   temp_off_q   <= pwdata[7:0];
        RegSpeedCeil: speed_ceil_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegLineThr:   prdata = ApbDataW'(line_thr_q);
      RegTempOff:   prdata = ApbDataW'(temp_off_q[7:0]);
      RegSpeedCeil: prdata = ApbDataW'(speed_ceil_q);
      default:      prdata = '0;
    endcase
  end

  fsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .line_thr_i    (line_thr_q),
    .temp_offset_i (temp_off_q),
    .job_o         (front_job),
    .job_valid_o   (front_valid),
    .job_ready_i   (front_ready)
  );

  fsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  fsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (back_job),
    .job_valid_i  (back_valid),
    .job_ready_o  (back_ready),
    .speed_ceil_i (speed_ceil_q),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] RegUnused = 2'd3;   // no register behind this index
  localparam int SettleCycles  = 20;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;

  typedef struct packed {
    logic signed [7:0] temp;
    logic [8:0]        volts;
    logic [11:0]       watts;
  } sensor_set_t;

  typedef struct packed {
    logic [14:0] speed;
    logic        line_hi;
  } fan_cmd_t;

  logic clk;
  logic rst_ni = 1'b0;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [fsc_pkg::ApbAddrW-1:0] paddr;
  logic [fsc_pkg::ApbDataW-1:0] pwdata;
  logic [fsc_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  fsc_in_if  sensor_bus ();
  fsc_out_if cmd_bus ();

  fan_speed_curve_unit uut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .item_i   (sensor_bus),
    .result_o (cmd_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register copies used by the speed prediction
  logic [8:0]        line_thr   = fsc_pkg::LineThrRst;
  logic signed [7:0] temp_off   = fsc_pkg::TempOffRst;
  logic [14:0]       speed_ceil = fsc_pkg::SpeedCeilRst;

  fan_cmd_t cmds_due[$];
  int       error_count   = 0;
  bit       tx_idle       = 1'b1;
  bit       rx_idle       = 1'b1;
  int       rx_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int ramp(int x, int xmin, int xmax, int k, int b, int ymin, int ymax);
    int v;
    if (x < xmin) return ymin;
    if (x > xmax) return ymax;
    v = (x - xmin) * k + b;
    if (v < ymin) v = ymin;
    if (v > ymax) v = ymax;
    return v;
  endfunction

  function automatic fan_cmd_t fan_curve_speed(sensor_set_t s);
    fan_cmd_t r;
    int       t, volts, watts, load_max, vnom, loff, k_steep, k_gentle, d, speed, y;
    longint   fact, boost;
    logic     hi;
    hi       = (s.volts > line_thr);
    volts    = int'(s.volts);
    watts    = int'(s.watts);
    load_max = hi ? 2000 : 1250;
    vnom     = hi ? 215 : 105;
    loff     = hi ? 54 : 34;
    k_steep  = hi ? 1728 : 2764;
    k_gentle = hi ? 192 : 307;
    fact     = hi ? 262 : 419;
    t = int'($signed(s.temp)) - int'($signed(temp_off));

    if (t >= 28) speed = ramp(t, 28, 55, 333, 9000, 9000, 18000);
    else if (t >= 25) speed = 9000;
    else if (t >= 18) speed = ramp(t, 18, 25, 314, 6800, 6800, 9000);
    else if (t >= 15) speed = 6800;
    else if (t >= 3) speed = ramp(t, 3, 15, 100, 5600, 5600, 6800);
    else if (t >= -20) speed = 5600;
    else if (t > -33) speed = ramp(t, -33, -20, 200, 3000, 3000, 5600);
    else speed = 3000;

    // load term: the shifts floor, as an arithmetic shift does
    d = watts - load_max;
    if (100 * d > 3 * load_max) speed += (k_steep * (d - loff)) >>> 7;
    else if (d >= -(load_max / 2)) speed += (k_gentle * d) >>> 7;
    else speed -= 1500;

    if (volts < vnom) begin
      y = hi ? ramp(volts, 176, 205, 129, 0, 0, 3750) : ramp(volts, 90, 105, 250, 0, 0, 3750);
      boost = longint'(3750 - y) * longint'(watts) * fact;
      speed += int'(boost >>> 19);
    end

    if (speed < 0) speed = 0;
    if (speed > int'(speed_ceil)) speed = int'(speed_ceil);
    r.speed   = speed[14:0];
    r.line_hi = hi;
    return r;
  endfunction

  function automatic sensor_set_t draw_sensor_set();
    sensor_set_t s;
    int          t, v, w;
    if ($urandom_range(0, 1) == 0) begin
      t = int'($urandom_range(0, 191)) - 64;
    end else begin
      // aim at the bands around the curve knees
      t = int'($signed(temp_off)) + int'($urandom_range(0, 110)) - 45;
      if (t < -64) t = -64;
      if (t > 127) t = 127;
    end
    case ($urandom_range(0, 4))
      0, 1: v = int'($urandom_range(0, 511));
      2: v = int'(line_thr) + int'($urandom_range(0, 6)) - 3;
      3: v = 84 + int'($urandom_range(0, 26));
      default: v = 170 + int'($urandom_range(0, 50));
    endcase
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    if ($urandom_range(0, 4) < 2) begin
      w = int'($urandom_range(0, 4095));
    end else begin
      w = ((v > int'(line_thr)) ? 2000 : 1250) + int'($urandom_range(0, 1400)) - 700;
      if (w < 0) w = 0;
    end
    s.temp  = t[7:0];
    s.volts = v[8:0];
    s.watts = w[11:0];
    return s;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_sensor_set(input sensor_set_t s);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 14)) : 0;
    if (gap > 0) begin
      sensor_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor_bus.valid        <= 1'b1;
    sensor_bus.inlet_temp_c <= s.temp;
    sensor_bus.input_volts  <= s.volts;
    sensor_bus.output_watts <= s.watts;
    do @(posedge clk); while (!sensor_bus.ready);
    cmds_due.push_back(fan_curve_speed(s));
  endtask

  task automatic send_point(input int temp, input int volts, input int watts);
    sensor_set_t s;
    s.temp  = temp[7:0];
    s.volts = volts[8:0];
    s.watts = watts[11:0];
    send_sensor_set(s);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sensor_set(draw_sensor_set());
  endtask

  // Drop valid, wait for every command still owed, then let the pipe run dry
  task automatic settle_pipeline();
    sensor_bus.valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask, data;
    case (idx)
      fsc_pkg::RegLineThr:   mask = 32'h0000_01FF;
      fsc_pkg::RegTempOff:   mask = 32'h0000_00FF;
      fsc_pkg::RegSpeedCeil: mask = 32'h0000_7FFF;
      default:               mask = 32'h0000_0000;
    endcase
    // random junk above the register width must be dropped
    data = ($urandom() & ~mask) | (value & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      fsc_pkg::RegLineThr:   line_thr   = data[8:0];
      fsc_pkg::RegTempOff:   temp_off   = data[7:0];
      fsc_pkg::RegSpeedCeil: speed_ceil = data[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_curve(input int thr, input int off, input int ceil);
    write_reg(fsc_pkg::RegLineThr, 32'(thr));
    write_reg(fsc_pkg::RegTempOff, 32'(off));
    write_reg(fsc_pkg::RegSpeedCeil, 32'(ceil));
  endtask

  // Band edges of the temperature curve, line and load edges, boost edges
  task automatic test_reset_points();
    int off;
    off = int'($signed(temp_off));
    send_point(off - 33, 0, 0);
    send_point(off - 32, 89, 624);
    send_point(off - 21, 90, 625);
    send_point(off - 20, 104, 1249);
    send_point(off + 2, 105, 1287);
    send_point(off + 3, 150, 1288);
    send_point(off + 14, 151, 999);
    send_point(off + 15, 175, 1000);
    send_point(off + 17, 176, 2060);
    send_point(off + 18, 205, 2061);
    send_point(off + 24, 214, 4095);
    send_point(off + 25, 215, 0);
    send_point(off + 27, 511, 4095);
    send_point(off + 28, 100, 4095);
    send_point(off + 55, 200, 1999);
    send_point(off + 56, 300, 2000);
    send_point(off - 1, 106, 1251);
    send_point(off, 216, 2001);
    send_point(-64, 0, 4095);
    send_point(127, 511, 0);
    settle_pipeline();
  endtask

  task automatic test_register_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_curve(0, -64, 0);
    send_point(-64, 0, 0);
    send_point(127, 1, 4095);
    send_random(48);
    settle_pipeline();
    set_curve(511, 127, 32767);
    send_point(-64, 511, 4095);
    send_point(127, 100, 4095);
    send_random(48);
    settle_pipeline();
    set_curve(511, -64, 32767);
    send_point(127, 0, 4095);
    send_random(49);
    settle_pipeline();
    set_curve(0, 127, 9000);
    send_random(50);
    settle_pipeline();
    set_curve($urandom_range(0, 511), int'($urandom_range(0, 191)) - 64, $urandom_range(0, 32767));
    send_random(50);
    settle_pipeline();
    // back to reset values; a write to the spare index must change nothing
    set_curve(fsc_pkg::LineThrRst, fsc_pkg::TempOffRst, fsc_pkg::SpeedCeilRst);
    write_reg(RegUnused, $urandom());
    send_random(50);
    settle_pipeline();
  endtask

  task automatic test_random_mix();
    for (int chunk = 0; chunk < 6; chunk++) begin
      tx_idle = (chunk % 4 == 0) || (chunk % 4 == 2);
      rx_idle = (chunk % 4 == 0) || (chunk % 4 == 3);
      if (chunk % 3 == 2) begin
        set_curve(150 + int'($urandom_range(0, 60)) - 30,
                  int'($urandom_range(0, 40)) + 5, 18000 + int'($urandom_range(0, 14767)));
      end else begin
        set_curve($urandom_range(0, 511), int'($urandom_range(0, 191)) - 64,
                  $urandom_range(0, 32767));
      end
      send_random(150);
      settle_pipeline();
    end
  endtask

  // Hold the output long enough for the queue to fill and block the input
  task automatic test_output_hold();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    rx_hold_cycles = HoldCycles;
    send_random(40);
    settle_pipeline();
  endtask

  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) begin
      send_random(10);
      settle_pipeline();
    end
  endtask

  initial begin
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    sensor_bus.valid        <= 1'b0;
    sensor_bus.inlet_temp_c <= '0;
    sensor_bus.input_volts  <= '0;
    sensor_bus.output_watts <= '0;
    rst_ni                  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_points();
    test_register_extremes();
    test_random_mix();
    test_output_hold();
    test_sender_pause();

    if (error_count == 0) begin
      $display("fan_speed_curve_unit test passed");
    end else begin
      $display("fan_speed_curve_unit test failed");
    end
    $finish;
  end

  // Command receiver and checker
  initial begin
    fan_cmd_t want;
    int       stall;
    cmd_bus.ready <= 1'b0;
    while (!rst_ni) @(posedge clk);
    forever begin
      stall = rx_idle ? int'($urandom_range(0, 14)) : 0;
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        cmd_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_bus.ready <= 1'b1;
      do @(posedge clk); while (!cmd_bus.valid);
      if (cmds_due.size() == 0) begin
        report_error($sformatf("fan command %0d with no sensor set pending", cmd_bus.fan_speed));
      end else begin
        want = cmds_due.pop_front();
        if (cmd_bus.fan_speed !== want.speed)
          report_error($sformatf("fan_speed got %0d expected %0d",
                                 cmd_bus.fan_speed, want.speed));
        if (cmd_bus.line_is_high !== want.line_hi)
          report_error($sformatf("line_is_high got %0b expected %0b",
                                 cmd_bus.line_is_high, want.line_hi));
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves an item
  initial begin
    int quiet;
    quiet = 0;
    while (!rst_ni) @(posedge clk);
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((sensor_bus.valid && sensor_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("fan_speed_curve_unit test failed");
    $finish;
  end

endmodule
